@@ rtl/core/lc3x_pkg.sv @@
// Package for the LC-3 instruction executor: sizes, codes, small helpers.
// Used by the register file and the top level.
package lc3x_pkg;

    localparam int MEM_WORDS  = 65536;
    localparam int AW         = $clog2(MEM_WORDS);
    localparam int PUTS_LIMIT = 63;
    localparam int CNT_W      = $clog2(PUTS_LIMIT + 1);

    localparam logic [15:0] RESET_PC = 16'h3000;

    // request modes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_EXEC    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // configuration register indexes
    localparam logic CFG_START_PC = 1'b0;
    localparam logic CFG_TASK_ID  = 1'b1;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_ZERO    = 3'd2;
    localparam logic [2:0] ST_UNDEF   = 3'd3;
    localparam logic [2:0] ST_UNSUP   = 3'd4;
    localparam logic [2:0] ST_NOT_RUN = 3'd5;
    localparam logic [2:0] ST_TRUNC   = 3'd6;

    // condition codes
    localparam logic [2:0] CC_N = 3'h4;
    localparam logic [2:0] CC_Z = 3'h2;
    localparam logic [2:0] CC_P = 3'h1;

    // opcodes
    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_JSR  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_LDR  = 4'd6;
    localparam logic [3:0] OP_STR  = 4'd7;
    localparam logic [3:0] OP_NOT  = 4'd9;
    localparam logic [3:0] OP_LDI  = 4'd10;
    localparam logic [3:0] OP_STI  = 4'd11;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_LEA  = 4'd14;
    localparam logic [3:0] OP_TRAP = 4'd15;

    // trap vectors
    localparam logic [7:0] TV_GETC  = 8'h20;
    localparam logic [7:0] TV_OUT   = 8'h21;
    localparam logic [7:0] TV_PUTS  = 8'h22;
    localparam logic [7:0] TV_IN    = 8'h23;
    localparam logic [7:0] TV_PUTSP = 8'h24;
    localparam logic [7:0] TV_HALT  = 8'h25;
    localparam logic [7:0] TV_GETID = 8'h26;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;

    typedef struct packed {
        logic        we;
        logic [2:0]  addr;
        logic [15:0] data;
    } t_rf_wr;

    function automatic logic [17:0] sx9(input logic [15:0] ir);
        sx9 = {{9{ir[8]}}, ir[8:0]};
    endfunction

    function automatic logic [17:0] sx6(input logic [15:0] ir);
        sx6 = {{12{ir[5]}}, ir[5:0]};
    endfunction

    function automatic logic [15:0] sx11(input logic [15:0] ir);
        sx11 = {{5{ir[10]}}, ir[10:0]};
    endfunction

    function automatic logic [15:0] sx5(input logic [15:0] ir);
        sx5 = {{11{ir[4]}}, ir[4:0]};
    endfunction

    // an address is formed in 18 signed bits; negative or too large is out of range
    function automatic logic addr_bad(input logic [17:0] a);
        addr_bad = a[17] || (a[16:0] >= 17'(MEM_WORDS));
    endfunction

    function automatic logic [AW-1:0] addr_map(input logic [17:0] a);
        addr_map = addr_bad(a) ? '0 : a[AW-1:0];
    endfunction

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        if (v == 16'd0) begin
            cc_of = CC_Z;
        end else if (v[15]) begin
            cc_of = CC_N;
        end else begin
            cc_of = CC_P;
        end
    endfunction

endpackage

@@ rtl/core/lc3x_if.sv @@
// Handshake channels of the LC-3 executor: request, result and configuration.
// Uses nothing from lc3x_pkg; all widths are plain numbers.
interface lc3x_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] load_address;
    logic [15:0] load_word;
    logic [7:0]  key_char;
    modport source (output valid, mode, load_address, load_word, key_char, input ready);
    modport sink (input valid, mode, load_address, load_word, key_char, output ready);
endinterface

interface lc3x_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] next_pc;
    logic        char_valid;
    logic [7:0]  out_char;
    logic        bound_error;
    logic        last;
    modport source (output valid, status, next_pc, char_valid, out_char, bound_error, last,
                    input ready);
    modport sink (input valid, status, next_pc, char_valid, out_char, bound_error, last,
                  output ready);
endinterface

interface lc3x_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/lc3x_regfile.sv @@
// Eight-entry register file, one write and one registered read per cycle.
// Valid bits make cleared entries read as zero; depends on lc3x_pkg.
module lc3x_regfile (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clr,
    input  lc3x_pkg::t_rf_wr     i_wr,
    input  logic [2:0]           i_raddr,
    output logic [15:0]          o_rdata
);
    logic [15:0] r_mem [8];
    logic [7:0]  r_vld;
    logic [15:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= '0;
        end else if (i_wr.we) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        // forward a same-cycle write
        if (i_wr.we && i_wr.addr == i_raddr) begin
            r_q <= i_wr.data;
        end else if (r_vld[i_raddr]) begin
            r_q <= r_mem[i_raddr];
        end else begin
            r_q <= 16'd0;
        end
    end

    assign o_rdata = r_q;
endmodule

@@ rtl/core/lc3_instruction_executor.sv @@
// Top level of the LC-3 instruction executor: sequencer, word memory, output stage.
// Depends on lc3x_pkg, the channel interfaces in lc3x_if and lc3x_regfile.
//
//  channel    dir  payload                                           accepted when
//  i_item     in   mode, load_address, load_word, key_char           valid & ready
//  o_result   out  status, next_pc, char_valid, out_char,            valid & ready
//                  bound_error, last
//  i_cfg      in   index (0 start_pc, 1 task_id), data               valid & ready
//
// From accept to the final result, with no stalls: a load, a restart or an execute while
// stopped goes from idle straight to the result. An instruction is fetched, reads its
// registers and executes; LD, LDR, STI, LDI and the traps add word memory reads, and PUTS
// reads one word per character. Each step waits on the single-port, registered reads of
// the word memory and register file, which a fetch and up to two dependent reads chain
// through.
// After reset the block sweeps all MEM_WORDS (65536) words of the word memory to zero,
// and takes no request meanwhile; configuration writes are taken at all times.
// A stalled result holds the sequencer only where it must emit the next result.
module lc3_instruction_executor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lc3x_in_if.sink      i_item,
    lc3x_out_if.source   o_result,
    lc3x_cfg_if.sink     i_cfg
);
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_IR   = 4'd2;
    localparam logic [3:0] S_RA   = 4'd3;
    localparam logic [3:0] S_EX   = 4'd4;
    localparam logic [3:0] S_M1   = 4'd5;
    localparam logic [3:0] S_M2   = 4'd6;
    localparam logic [3:0] S_T1   = 4'd7;
    localparam logic [3:0] S_T2   = 4'd8;
    localparam logic [3:0] S_IN2  = 4'd9;
    localparam logic [3:0] S_PS   = 4'd10;
    localparam logic [3:0] S_PR   = 4'd11;
    localparam logic [3:0] S_W7   = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    localparam int CNT_W_L = lc3x_pkg::CNT_W;

    // architectural and sequencer state
    logic [3:0]  r_state, n_state;
    logic [15:0] r_pc, n_pc;
    logic [2:0]  r_cc, n_cc;
    logic        r_run, n_run;
    logic [15:0] r_ir, n_ir;
    logic [15:0] r_a, n_a;
    logic [15:0] r_b, n_b;
    logic [16:0] r_ptr, n_ptr;
    logic [CNT_W_L-1:0] r_cnt, n_cnt;
    logic [2:0]  r_status, n_status;
    logic        r_bad, n_bad;
    logic [7:0]  r_key, n_key;
    logic [lc3x_pkg::AW-1:0] r_clr_addr;
    logic [15:0] r_start_pc, r_task_id;

    // word memory ports
    logic [15:0] r_mem [lc3x_pkg::MEM_WORDS];
    logic        mem_we, mem_re;
    logic [lc3x_pkg::AW-1:0] mem_wa, mem_ra;
    logic [15:0] mem_wd, r_mem_q;

    // register file ports
    lc3x_pkg::t_rf_wr rf_wr;
    logic        rf_clr;
    logic [2:0]  rf_ra;
    logic [15:0] rf_q;

    // output stage
    logic        r_ov;
    logic [2:0]  r_o_status;
    logic [15:0] r_o_pc;
    logic        r_o_cv;
    logic [7:0]  r_o_char;
    logic        r_o_bad;
    logic        r_o_last;
    logic        out_free;
    logic        emit;
    logic [2:0]  e_status;
    logic        e_cv;
    logic [7:0]  e_char;
    logic        e_bad;
    logic        e_last;

    logic        accept;
    logic [3:0]  opc;
    logic [17:0] a_rel9, a_base6, a_tmp;
    logic [15:0] alu_b, alu_r;

    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_ov || o_result.ready;
    assign opc      = r_ir[15:12];
    assign a_rel9   = {2'b00, r_pc} + lc3x_pkg::sx9(r_ir);
    assign a_base6  = {2'b00, r_a} + lc3x_pkg::sx6(r_ir);
    assign alu_b    = r_ir[5] ? lc3x_pkg::sx5(r_ir) : rf_q;

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    lc3x_regfile u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (rf_clr),
        .i_wr    (rf_wr),
        .i_raddr (rf_ra),
        .o_rdata (rf_q)
    );

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_cc     = r_cc;
        n_run    = r_run;
        n_ir     = r_ir;
        n_a      = r_a;
        n_b      = r_b;
        n_ptr    = r_ptr;
        n_cnt    = r_cnt;
        n_status = r_status;
        n_bad    = r_bad;
        n_key    = r_key;
        mem_we   = 1'b0;
        mem_wa   = r_clr_addr;
        mem_wd   = 16'd0;
        mem_re   = 1'b0;
        mem_ra   = '0;
        rf_wr    = '0;
        rf_clr   = 1'b0;
        rf_ra    = 3'd0;
        emit     = 1'b0;
        e_status = r_status;
        e_cv     = 1'b0;
        e_char   = 8'd0;
        e_bad    = 1'b0;
        e_last   = 1'b0;
        alu_r    = 16'd0;
        a_tmp    = 18'd0;

        case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                if (r_clr_addr == lc3x_pkg::AW'(lc3x_pkg::MEM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_bad    = 1'b0;
                    n_status = lc3x_pkg::ST_OK;
                    n_key    = (i_item.key_char == lc3x_pkg::CH_CR) ?
                               lc3x_pkg::CH_LF : i_item.key_char;
                    n_state  = S_DONE;
                    case (i_item.mode)
                        lc3x_pkg::MODE_LOAD: begin
                            a_tmp  = {2'b00, i_item.load_address};
                            mem_we = 1'b1;
                            mem_wa = lc3x_pkg::addr_map(a_tmp);
                            mem_wd = i_item.load_word;
                            n_bad  = lc3x_pkg::addr_bad(a_tmp);
                        end
                        lc3x_pkg::MODE_RESTART: begin
                            rf_clr = 1'b1;
                            n_cc   = lc3x_pkg::CC_Z;
                            n_pc   = r_start_pc;
                            n_run  = 1'b1;
                        end
                        lc3x_pkg::MODE_EXEC: begin
                            if (!r_run) begin
                                n_status = lc3x_pkg::ST_NOT_RUN;
                            end else begin
                                a_tmp   = {2'b00, r_pc};
                                mem_re  = 1'b1;
                                mem_ra  = lc3x_pkg::addr_map(a_tmp);
                                n_bad   = lc3x_pkg::addr_bad(a_tmp);
                                n_state = S_IR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_IR: begin
                // latch the instruction, advance the PC, read SR1
                n_ir    = r_mem_q;
                n_pc    = r_pc + 16'd1;
                rf_ra   = r_mem_q[8:6];
                n_state = S_RA;
            end
            S_RA: begin
                n_a = rf_q;
                case (opc)
                    lc3x_pkg::OP_ADD, lc3x_pkg::OP_AND: rf_ra = r_ir[2:0];
                    lc3x_pkg::OP_ST, lc3x_pkg::OP_STI, lc3x_pkg::OP_STR: rf_ra = r_ir[11:9];
                    default: rf_ra = 3'd0;
                endcase
                n_state = S_EX;
            end
            S_EX: begin
                n_b     = rf_q;
                n_state = S_DONE;
                case (opc)
                    lc3x_pkg::OP_ADD, lc3x_pkg::OP_AND, lc3x_pkg::OP_NOT: begin
                        if (opc == lc3x_pkg::OP_ADD) begin
                            alu_r = r_a + alu_b;
                        end else if (opc == lc3x_pkg::OP_AND) begin
                            alu_r = r_a & alu_b;
                        end else begin
                            alu_r = ~r_a;
                        end
                        rf_wr = '{we: 1'b1, addr: r_ir[11:9], data: alu_r};
                        n_cc  = lc3x_pkg::cc_of(alu_r);
                    end
                    lc3x_pkg::OP_BR: begin
                        if (r_ir == 16'd0) begin
                            n_run    = 1'b0;
                            n_status = lc3x_pkg::ST_ZERO;
                        end else if ((r_ir[11:9] & r_cc) != 3'd0) begin
                            n_pc = a_rel9[15:0];
                        end
                    end
                    lc3x_pkg::OP_JMP: n_pc = r_a;
                    lc3x_pkg::OP_JSR: begin
                        n_pc  = r_ir[11] ? (r_pc + lc3x_pkg::sx11(r_ir)) : r_a;
                        rf_wr = '{we: 1'b1, addr: 3'd7, data: r_pc};
                    end
                    lc3x_pkg::OP_LEA: begin
                        rf_wr = '{we: 1'b1, addr: r_ir[11:9], data: a_rel9[15:0]};
                        n_cc  = lc3x_pkg::cc_of(a_rel9[15:0]);
                    end
                    lc3x_pkg::OP_LD, lc3x_pkg::OP_LDI, lc3x_pkg::OP_STI,
                    lc3x_pkg::OP_LDR: begin
                        a_tmp   = (opc == lc3x_pkg::OP_LDR) ? a_base6 : a_rel9;
                        mem_re  = 1'b1;
                        mem_ra  = lc3x_pkg::addr_map(a_tmp);
                        n_bad   = r_bad | lc3x_pkg::addr_bad(a_tmp);
                        n_state = S_M1;
                    end
                    lc3x_pkg::OP_ST, lc3x_pkg::OP_STR: begin
                        a_tmp  = (opc == lc3x_pkg::OP_STR) ? a_base6 : a_rel9;
                        mem_we = 1'b1;
                        mem_wa = lc3x_pkg::addr_map(a_tmp);
                        mem_wd = rf_q;
                        n_bad  = r_bad | lc3x_pkg::addr_bad(a_tmp);
                    end
                    lc3x_pkg::OP_TRAP: begin
                        a_tmp   = {10'd0, r_ir[7:0]};
                        mem_re  = 1'b1;
                        mem_ra  = lc3x_pkg::addr_map(a_tmp);
                        n_bad   = r_bad | lc3x_pkg::addr_bad(a_tmp);
                        n_state = S_T1;
                    end
                    default: begin
                        n_run    = 1'b0;
                        n_status = lc3x_pkg::ST_UNDEF;
                    end
                endcase
            end
            S_M1: begin
                a_tmp   = {2'b00, r_mem_q};
                n_state = S_DONE;
                case (opc)
                    lc3x_pkg::OP_LDI: begin
                        mem_re  = 1'b1;
                        mem_ra  = lc3x_pkg::addr_map(a_tmp);
                        n_bad   = r_bad | lc3x_pkg::addr_bad(a_tmp);
                        n_state = S_M2;
                    end
                    lc3x_pkg::OP_STI: begin
                        mem_we = 1'b1;
                        mem_wa = lc3x_pkg::addr_map(a_tmp);
                        mem_wd = r_b;
                        n_bad  = r_bad | lc3x_pkg::addr_bad(a_tmp);
                    end
                    default: begin
                        rf_wr = '{we: 1'b1, addr: r_ir[11:9], data: r_mem_q};
                        n_cc  = lc3x_pkg::cc_of(r_mem_q);
                    end
                endcase
            end
            S_M2: begin
                rf_wr   = '{we: 1'b1, addr: r_ir[11:9], data: r_mem_q};
                n_cc    = lc3x_pkg::cc_of(r_mem_q);
                n_state = S_DONE;
            end
            S_T1: begin
                // dereference the vector; only the bound check matters
                a_tmp   = {2'b00, r_mem_q};
                mem_re  = 1'b1;
                mem_ra  = lc3x_pkg::addr_map(a_tmp);
                n_bad   = r_bad | lc3x_pkg::addr_bad(a_tmp);
                n_state = S_T2;
            end
            S_T2: begin
                case (r_ir[7:0])
                    lc3x_pkg::TV_GETID: begin
                        rf_wr   = '{we: 1'b1, addr: 3'd0, data: r_task_id};
                        n_state = S_W7;
                    end
                    lc3x_pkg::TV_GETC: begin
                        rf_wr   = '{we: 1'b1, addr: 3'd0, data: {8'd0, r_key}};
                        n_state = S_W7;
                    end
                    lc3x_pkg::TV_OUT, lc3x_pkg::TV_PUTSP, lc3x_pkg::TV_IN: begin
                        if (out_free) begin
                            emit = 1'b1;
                            e_status = lc3x_pkg::ST_OK;
                            e_cv = 1'b1;
                            if (r_ir[7:0] == lc3x_pkg::TV_OUT) begin
                                e_char = r_b[7:0];
                            end else if (r_ir[7:0] == lc3x_pkg::TV_PUTSP) begin
                                e_char = lc3x_pkg::CH_SPACE;
                            end else begin
                                e_char = lc3x_pkg::CH_COLON;
                            end
                            n_state = (r_ir[7:0] == lc3x_pkg::TV_IN) ? S_IN2 : S_W7;
                        end
                    end
                    lc3x_pkg::TV_PUTS: begin
                        n_ptr   = {1'b0, r_b};
                        n_cnt   = '0;
                        n_state = S_PS;
                    end
                    lc3x_pkg::TV_HALT: begin
                        n_run    = 1'b0;
                        n_status = lc3x_pkg::ST_HALT;
                        n_state  = S_W7;
                    end
                    default: begin
                        n_status = lc3x_pkg::ST_UNSUP;
                        n_state  = S_DONE;
                    end
                endcase
            end
            S_IN2: begin
                rf_wr   = '{we: 1'b1, addr: 3'd0, data: {8'd0, r_key}};
                n_state = S_W7;
            end
            S_PS: begin
                a_tmp   = {1'b0, r_ptr};
                mem_re  = 1'b1;
                mem_ra  = lc3x_pkg::addr_map(a_tmp);
                n_bad   = r_bad | lc3x_pkg::addr_bad(a_tmp);
                n_state = S_PR;
            end
            S_PR: begin
                if (r_mem_q == 16'd0) begin
                    n_state = S_W7;
                end else if (r_cnt == CNT_W_L'(lc3x_pkg::PUTS_LIMIT)) begin
                    n_status = lc3x_pkg::ST_TRUNC;
                    n_state  = S_W7;
                end else if (out_free) begin
                    emit     = 1'b1;
                    e_status = lc3x_pkg::ST_OK;
                    e_cv     = 1'b1;
                    e_char   = r_mem_q[7:0];
                    n_ptr    = r_ptr + 17'd1;
                    n_cnt    = r_cnt + CNT_W_L'(1);
                    n_state  = S_PS;
                end
            end
            S_W7: begin
                rf_wr   = '{we: 1'b1, addr: 3'd7, data: r_pc};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_bad   = r_bad;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // word memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_pc       <= lc3x_pkg::RESET_PC;
            r_cc       <= lc3x_pkg::CC_Z;
            r_run      <= 1'b0;
            r_start_pc <= lc3x_pkg::RESET_PC;
            r_task_id  <= 16'd0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cc    <= n_cc;
            r_run   <= n_run;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + lc3x_pkg::AW'(1);
            end
            if (i_cfg.valid) begin
                if (i_cfg.index == lc3x_pkg::CFG_START_PC) begin
                    r_start_pc <= i_cfg.data;
                end else begin
                    r_task_id <= i_cfg.data;
                end
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ir     <= n_ir;
        r_a      <= n_a;
        r_b      <= n_b;
        r_ptr    <= n_ptr;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_bad    <= n_bad;
        r_key    <= n_key;
        if (emit) begin
            r_o_status <= e_status;
            r_o_pc     <= n_pc;
            r_o_cv     <= e_cv;
            r_o_char   <= e_char;
            r_o_bad    <= e_bad;
            r_o_last   <= e_last;
        end
    end

    assign o_result.valid       = r_ov;
    assign o_result.status      = r_o_status;
    assign o_result.next_pc     = r_o_pc;
    assign o_result.char_valid  = r_o_cv;
    assign o_result.out_char    = r_o_char;
    assign o_result.bound_error = r_o_bad;
    assign o_result.last        = r_o_last;

    // no request is taken during the memory sweep
    a_clr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !i_item.ready)
        else $error("request ready during memory clear");

    // a character result never closes a request and is always ok
    a_char_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.char_valid |-> !o_result.last &&
        o_result.status == lc3x_pkg::ST_OK && !o_result.bound_error)
        else $error("malformed character result");

    // one request at a time: the sequencer leaves idle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_item.ready)
        else $error("second request accepted while busy");

    // an undefined opcode stops the core
    a_undef_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EX && (opc == 4'd8 || opc == 4'd13) |=> !r_run)
        else $error("core still running after undefined opcode");
endmodule
